@@ rtl/arg_pkg.sv @@
// Shared types and constants for the auto-ranging gain control block.
// Used by arg_lane, arg_merge and auto_range_gain_with_overvoltage.
`default_nettype none

package arg_pkg;

  // channel and range geometry
  localparam int MAX_CH       = 4;
  localparam int CHANNELS_DEF = 4;
  localparam int FS_NUM       = 6;
  localparam int GAIN_W       = 3;
  localparam logic [GAIN_W-1:0] GAIN_MAX = 3'd5;

  // field widths
  localparam int SAMPLE_W = 24;
  localparam int DELAY_W  = 24;
  localparam int VOLT_W   = 23;
  localparam int OVC_W    = 4;
  localparam int HI_W     = 28;  // 19 * full scale
  localparam int LO_W     = 25;  // 4 * full scale
  localparam int CFG_A_W  = 3;
  localparam int CFG_D_W  = 24;
  localparam int IN_D_W   = 96;
  localparam int OUT_D_W  = 24;

  // overvoltage count trips when it passes this value
  localparam logic [OVC_W-1:0] OV_TRIP = 4'd10;

  // register reset values
  localparam logic [DELAY_W-1:0] DELAY_RST  = 24'd8600;
  localparam logic [VOLT_W-1:0]  OV_LIM_RST = 23'd6000000;
  localparam logic [FS_NUM-1:0][VOLT_W-1:0] FS_RST = {
    23'd256000, 23'd512000, 23'd1024000, 23'd2048000, 23'd4096000, 23'd6144000
  };

  // configuration register indexes
  typedef enum logic [CFG_A_W-1:0] {
    REG_DELAY  = 3'd0,
    REG_OV_LIM = 3'd1,
    REG_FS0    = 3'd2,
    REG_FS1    = 3'd3,
    REG_FS2    = 3'd4,
    REG_FS3    = 3'd5,
    REG_FS4    = 3'd6,
    REG_FS5    = 3'd7
  } reg_idx_t;

  // scaled range thresholds handed to every lane
  typedef struct packed {
    logic [FS_NUM-1:0][HI_W-1:0] hi;
    logic [FS_NUM-1:0][LO_W-1:0] lo;
  } arg_thr_t;

  // what one lane found for one item
  typedef struct packed {
    logic [GAIN_W-1:0] gain;
    logic              moved;
    logic              ov_flag;
  } arg_lane_res_t;

endpackage

`default_nettype wire

@@ rtl/arg_lane.sv @@
// One channel lane: gain index, down-range countdown and overvoltage count.
// Depends on arg_pkg for widths, thresholds and the lane result struct.
`default_nettype none

module arg_lane (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 en,
  input  wire logic signed [arg_pkg::SAMPLE_W-1:0]  sample,
  input  wire logic        [arg_pkg::DELAY_W-1:0]   delay_cnt,
  input  wire logic        [arg_pkg::VOLT_W-1:0]    ov_limit,
  input  wire arg_pkg::arg_thr_t                    thr,
  output arg_pkg::arg_lane_res_t                    res
);

  logic [arg_pkg::GAIN_W-1:0]  gain_r, gain_nxt;
  logic [arg_pkg::DELAY_W-1:0] cd_r, cd_nxt;
  logic [arg_pkg::OVC_W-1:0]   ovc_r, ovc_nxt;

  logic [arg_pkg::SAMPLE_W-1:0]   raw;
  logic [arg_pkg::SAMPLE_W-1:0]   mag;
  logic [arg_pkg::HI_W:0]         mag20;
  logic [arg_pkg::LO_W+1:0]       mag5;
  logic [arg_pkg::FS_NUM-1:0]     hi_bits;
  logic [arg_pkg::FS_NUM-1:0]     lo_bits;
  logic [7:0]                     hi_pad;
  logic [7:0]                     lo_pad;
  logic [arg_pkg::DELAY_W-1:0]    cd0;
  logic [arg_pkg::DELAY_W-1:0]    cd1;
  logic [arg_pkg::OVC_W-1:0]      ovc_inc;
  logic                           widen;
  logic                           low_sig;
  logic                           narrow;
  logic                           ov_flag;
  logic [arg_pkg::GAIN_W-1:0]     g1;

  // magnitude, the most negative sample maps to 2^23
  assign raw   = sample;
  assign mag   = raw[arg_pkg::SAMPLE_W-1] ? (~raw + 24'd1) : raw;
  assign mag20 = ({5'd0, mag} << 4) + ({5'd0, mag} << 2);
  assign mag5  = ({3'd0, mag} << 2) + {3'd0, mag};

  // compare against every range at once, select by gain below
  always_comb begin
    for (int i = 0; i < arg_pkg::FS_NUM; i++) begin
      hi_bits[i] = mag20 > {1'b0, thr.hi[i]};
      lo_bits[i] = mag5 < {2'b0, thr.lo[i]};
    end
  end

  assign hi_pad = {2'b00, hi_bits};
  assign lo_pad = {2'b00, lo_bits};

  // per-item state update
  always_comb begin
    cd0     = (cd_r == '0) ? delay_cnt : cd_r;
    ovc_inc = ovc_r + 4'd1;
    ov_flag = 1'b0;
    ovc_nxt = ovc_r;
    if ({1'b0, mag} > {2'b00, ov_limit}) begin
      if (ovc_inc > arg_pkg::OV_TRIP) begin
        ov_flag = 1'b1;
        ovc_nxt = '0;
      end else begin
        ovc_nxt = ovc_inc;
      end
    end

    // widen at once on a large signal
    widen = (gain_r != '0) && hi_pad[gain_r];
    g1    = widen ? (gain_r - 3'd1) : gain_r;

    // after widening the next narrower range is the current one
    low_sig = widen ? lo_pad[gain_r]
                    : ((gain_r < arg_pkg::GAIN_MAX) && lo_pad[3'(gain_r + 3'd1)]);

    narrow = 1'b0;
    if (low_sig) begin
      cd1    = (cd0 != '0) ? (cd0 - 24'd1) : cd0;
      narrow = (cd1 == '0);
    end else begin
      cd1 = delay_cnt;
    end

    gain_nxt = narrow ? (g1 + 3'd1) : g1;
    cd_nxt   = cd1;

    res.gain    = gain_nxt;
    res.moved   = widen | narrow;
    res.ov_flag = ov_flag;
  end

  // lane state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= '0;
      cd_r   <= '0;
      ovc_r  <= '0;
    end else if (en) begin
      gain_r <= gain_nxt;
      cd_r   <= cd_nxt;
      ovc_r  <= ovc_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/arg_merge.sv @@
// Merges the lane results into one result item and buffers it two deep.
// Depends on arg_pkg for the lane result struct and field widths.
`default_nettype none

module arg_merge (
  input  wire logic                                       clk,
  input  wire logic                                       rst_n,
  input  wire logic                                       push,
  input  wire arg_pkg::arg_lane_res_t [arg_pkg::MAX_CH-1:0] lane_res,
  output logic                                            in_rdy,
  output logic                                            out_tvalid,
  input  wire logic                                       out_tready,
  output logic [arg_pkg::OUT_D_W-1:0]                     out_tdata
);

  logic [arg_pkg::OUT_D_W-1:0] item;
  logic [arg_pkg::OUT_D_W-1:0] main_r, main_nxt;
  logic [arg_pkg::OUT_D_W-1:0] skid_r, skid_nxt;
  logic                        mv_r, mv_nxt;
  logic                        sv_r, sv_nxt;
  logic                        pop;
  logic                        moved_any;
  logic [arg_pkg::MAX_CH-1:0]  ov_mask;

  // combine lanes: gains side by side, changed flag ored, mask collected
  always_comb begin
    moved_any = 1'b0;
    item      = '0;
    for (int c = 0; c < arg_pkg::MAX_CH; c++) begin
      item[c*arg_pkg::GAIN_W +: arg_pkg::GAIN_W] = lane_res[c].gain;
      moved_any  = moved_any | lane_res[c].moved;
      ov_mask[c] = lane_res[c].ov_flag;
    end
    item[arg_pkg::MAX_CH*arg_pkg::GAIN_W]                       = moved_any;
    item[arg_pkg::MAX_CH*arg_pkg::GAIN_W+1 +: arg_pkg::MAX_CH]  = ov_mask;
  end

  assign pop        = mv_r & out_tready;
  assign in_rdy     = ~sv_r;
  assign out_tvalid = mv_r;
  assign out_tdata  = main_r;

  // output register plus skid entry
  always_comb begin
    main_nxt = main_r;
    skid_nxt = skid_r;
    mv_nxt   = mv_r;
    sv_nxt   = sv_r;
    if (sv_r) begin
      if (pop) begin
        main_nxt = skid_r;
        sv_nxt   = 1'b0;
      end
    end else if (!mv_r || pop) begin
      if (push) begin
        main_nxt = item;
      end
      mv_nxt = push;
    end else if (push) begin
      skid_nxt = item;
      sv_nxt   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mv_r <= 1'b0;
      sv_r <= 1'b0;
    end else begin
      mv_r <= mv_nxt;
      sv_r <= sv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

endmodule

`default_nettype wire

@@ rtl/auto_range_gain_with_overvoltage.sv @@
// Auto-ranging gain control with overvoltage counting, top level.
// Holds the configuration registers; instantiates arg_lane and arg_merge; uses arg_pkg.
//
// Usage:
//   in_* takes one item per ready cycle: four signed 24-bit samples in microvolts.
//   out_* returns one item per input item: four gain indexes, a gain changed
//   flag and an overvoltage mask.
//   cfg_* writes a register at any edge with cfg_we high; write only while
//   no item is in flight.
// Timing:
//   each channel lane updates its state in the cycle an item is accepted, and the
//   result is registered into the output register, or into the skid entry when the
//   output register is held. Throughput is one item per clock while in_tready is high.
// Stall:
//   a two-entry output buffer (output register and skid entry) holds results;
//   in_tready drops only once both entries are full.
// Reset:
//   rst_n low (synchronous) clears the gain indexes, countdowns, overvoltage
//   counts and the output buffer, and loads the register reset values.
`default_nettype none

module auto_range_gain_with_overvoltage #(
  parameter int CHANNELS = arg_pkg::CHANNELS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // sample_ch0 [23:0], sample_ch1 [47:24], sample_ch2 [71:48], sample_ch3 [95:72]
  input  wire logic [arg_pkg::IN_D_W-1:0]    in_tdata,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  // gain_ch0 [2:0], gain_ch1 [5:3], gain_ch2 [8:6], gain_ch3 [11:9],
  // gain_changed [12], overvoltage_mask [16:13], zero fill [23:17]
  output logic [arg_pkg::OUT_D_W-1:0]        out_tdata,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  input  wire logic                          cfg_we,
  input  wire logic [arg_pkg::CFG_A_W-1:0]   cfg_addr,
  input  wire logic [arg_pkg::CFG_D_W-1:0]   cfg_wdata
);

  logic [arg_pkg::DELAY_W-1:0]                     delay_r;
  logic [arg_pkg::VOLT_W-1:0]                      ov_lim_r;
  logic [arg_pkg::FS_NUM-1:0][arg_pkg::VOLT_W-1:0] fs_r;
  arg_pkg::arg_thr_t                               thr;
  arg_pkg::arg_lane_res_t [arg_pkg::MAX_CH-1:0]    lane_res;
  logic                                            accept;

  assign accept = in_tvalid & in_tready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r  <= arg_pkg::DELAY_RST;
      ov_lim_r <= arg_pkg::OV_LIM_RST;
      fs_r     <= arg_pkg::FS_RST;
    end else if (cfg_we) begin
      unique case (arg_pkg::reg_idx_t'(cfg_addr))
        arg_pkg::REG_DELAY:  delay_r  <= cfg_wdata;
        arg_pkg::REG_OV_LIM: ov_lim_r <= cfg_wdata[arg_pkg::VOLT_W-1:0];
        arg_pkg::REG_FS0:    fs_r[0]  <= cfg_wdata[arg_pkg::VOLT_W-1:0];
        arg_pkg::REG_FS1:    fs_r[1]  <= cfg_wdata[arg_pkg::VOLT_W-1:0];
        arg_pkg::REG_FS2:    fs_r[2]  <= cfg_wdata[arg_pkg::VOLT_W-1:0];
        arg_pkg::REG_FS3:    fs_r[3]  <= cfg_wdata[arg_pkg::VOLT_W-1:0];
        arg_pkg::REG_FS4:    fs_r[4]  <= cfg_wdata[arg_pkg::VOLT_W-1:0];
        arg_pkg::REG_FS5:    fs_r[5]  <= cfg_wdata[arg_pkg::VOLT_W-1:0];
      endcase
    end
  end

  // scaled thresholds: 19/20 of full scale for widening, 4/5 for narrowing
  always_comb begin
    for (int i = 0; i < arg_pkg::FS_NUM; i++) begin
      thr.hi[i] = (arg_pkg::HI_W'(fs_r[i]) << 4) + (arg_pkg::HI_W'(fs_r[i]) << 1)
                + arg_pkg::HI_W'(fs_r[i]);
      thr.lo[i] = {fs_r[i], 2'b00};
    end
  end

  // one lane per channel, unused channels report zeros
  for (genvar c = 0; c < arg_pkg::MAX_CH; c++) begin : g_lane
    if (c < CHANNELS) begin : g_on
      arg_lane u_lane (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (accept),
        .sample    (in_tdata[c*arg_pkg::SAMPLE_W +: arg_pkg::SAMPLE_W]),
        .delay_cnt (delay_r),
        .ov_limit  (ov_lim_r),
        .thr       (thr),
        .res       (lane_res[c])
      );
    end else begin : g_off
      assign lane_res[c] = '0;
    end
  end

  arg_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (accept),
    .lane_res   (lane_res),
    .in_rdy     (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire

@@ test/tb_auto_range_gain_with_overvoltage.sv @@
// Testbench for auto_range_gain_with_overvoltage: directed and random sample sets,
// each result checked against a gain ranging predictor kept inside the bench.
// Depends on arg_pkg and the rtl top level.
`default_nettype none

module tb_auto_range_gain_with_overvoltage;
  import arg_pkg::*;

  // one result word, gain_ch0 in the lowest bits
  typedef struct packed {
    logic [6:0]                    fill;
    logic [MAX_CH-1:0]             ov_mask;
    logic                          changed;
    logic [MAX_CH-1:0][GAIN_W-1:0] gain;
  } gain_word_t;

  localparam int STUCK_LIMIT = 5000;
  localparam logic [SAMPLE_W-1:0] MOST_NEG = 24'h800000;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic [IN_D_W-1:0]   in_tdata  = '0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [OUT_D_W-1:0]  out_tdata;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic                cfg_we    = 1'b0;
  logic [CFG_A_W-1:0]  cfg_addr  = '0;
  logic [CFG_D_W-1:0]  cfg_wdata = '0;

  // register shadows and per-channel ranging state
  logic [DELAY_W-1:0] delay_cfg;
  logic [VOLT_W-1:0]  ov_limit_cfg;
  logic [VOLT_W-1:0]  fs_cfg [FS_NUM];
  logic [GAIN_W-1:0]  gain_st [MAX_CH];
  logic [DELAY_W-1:0] countdown_st [MAX_CH];
  logic [OVC_W-1:0]   ov_count_st [MAX_CH];
  int                 quiet_left [MAX_CH];

  gain_word_t expected_words[$];
  gain_word_t got_word, want_word;
  int         mismatch_count = 0;
  int         stuck_cycles   = 0;
  int         send_idle_pct  = 0;
  int         recv_stall_pct = 0;

  auto_range_gain_with_overvoltage uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // magnitude of a signed sample, most negative value included
  function automatic longint unsigned magnitude(logic [SAMPLE_W-1:0] s);
    if (s[SAMPLE_W-1]) return 64'h1000000 - longint'(s);
    return longint'(s);
  endfunction

  // advance the ranging state by one sample set and return the result word
  function automatic gain_word_t predict_ranging(logic [IN_D_W-1:0] samples);
    gain_word_t        r;
    longint unsigned   mag;
    longint unsigned   fs_val;
    int                g;
    r = '0;
    for (int c = 0; c < MAX_CH; c++) begin
      mag = magnitude(samples[c*SAMPLE_W +: SAMPLE_W]);
      g = gain_st[c];
      if (g > GAIN_MAX) g = GAIN_MAX;
      if (countdown_st[c] == 0) countdown_st[c] = delay_cfg;
      // overvoltage count, flag on its eleventh crossing
      if (mag > ov_limit_cfg) begin
        ov_count_st[c] = ov_count_st[c] + 1'b1;
        if (ov_count_st[c] > OV_TRIP) begin
          r.ov_mask[c] = 1'b1;
          ov_count_st[c] = '0;
        end
      end
      // widen at once above 19/20 of the current full scale
      fs_val = fs_cfg[g];
      if (g > 0 && 20 * mag > 19 * fs_val) begin
        g--;
        r.changed = 1'b1;
      end
      // narrow after a run of magnitudes below 4/5 of the next full scale
      if (g < GAIN_MAX) fs_val = fs_cfg[g+1];
      if (g < GAIN_MAX && 5 * mag < 4 * fs_val) begin
        if (countdown_st[c] > 0) countdown_st[c] = countdown_st[c] - 1'b1;
        if (countdown_st[c] == 0) begin
          g++;
          r.changed = 1'b1;
        end
      end else begin
        countdown_st[c] = delay_cfg;
      end
      gain_st[c] = g[GAIN_W-1:0];
      r.gain[c]  = g[GAIN_W-1:0];
    end
    return r;
  endfunction

  // sample aimed at the thresholds of the channel's present range
  function automatic logic [SAMPLE_W-1:0] pick_sample(int c);
    longint mag;
    longint f_hi;
    longint f_lo;
    int     g;
    int     r;
    g    = gain_st[c];
    f_hi = fs_cfg[g];
    f_lo = (g < GAIN_MAX) ? fs_cfg[g+1] : fs_cfg[g];
    r    = $urandom_range(99);
    if (quiet_left[c] > 0) begin
      quiet_left[c]--;
      mag = $urandom_range(0, int'(f_lo * 3 / 4));
    end else if (r < 10) begin
      quiet_left[c] = $urandom_range(2, 15);
      mag = $urandom_range(0, int'(f_lo / 2));
    end else if (r < 35) begin
      mag = f_hi * 19 / 20 + $urandom_range(0, 4) - 2;
    end else if (r < 55) begin
      mag = f_lo * 4 / 5 + $urandom_range(0, 4) - 2;
    end else if (r < 67) begin
      mag = longint'(ov_limit_cfg) + $urandom_range(0, 4) - 2;
    end else if (r < 80) begin
      return SAMPLE_W'($urandom);
    end else if (r < 88) begin
      case ($urandom_range(4))
        0: return '0;
        1: return MOST_NEG;
        2: return 24'h7fffff;
        3: return 24'hffffff;
        default: return 24'h000001;
      endcase
    end else begin
      mag = $urandom_range(0, 6144000);
    end
    if (mag < 0) mag = 0;
    if (mag >= 64'h800000) return MOST_NEG;
    if ($urandom_range(1)) return -mag[SAMPLE_W-1:0];
    return mag[SAMPLE_W-1:0];
  endfunction

  task automatic report_field(string field, int want, int got);
    if (want != got) begin
      mismatch_count++;
      $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
    end
  endtask

  // offer one sample set and record its expected result once accepted
  task automatic send_samples(input logic [IN_D_W-1:0] samples);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tdata  = samples;
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    expected_words.push_back(predict_ranging(samples));
    @(negedge clk);
  endtask

  // wait until every expected result has come out
  task automatic drain();
    in_tvalid = 1'b0;
    while (expected_words.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [CFG_D_W-1:0] value);
    cfg_we    = 1'b1;
    cfg_addr  = idx;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we    = 1'b0;
    case (idx)
      REG_DELAY:  delay_cfg    = value;
      REG_OV_LIM: ov_limit_cfg = value[VOLT_W-1:0];
      default:    fs_cfg[int'(idx) - int'(REG_FS0)] = value[VOLT_W-1:0];
    endcase
  endtask

  // rewrite every register; the unused top data bit gets random content
  task automatic program_registers(input logic [DELAY_W-1:0] delay,
                                   input logic [VOLT_W-1:0] ov_limit,
                                   input logic [FS_NUM-1:0][VOLT_W-1:0] fs);
    drain();
    write_reg(REG_DELAY, delay);
    write_reg(REG_OV_LIM, {1'($urandom_range(1)), ov_limit});
    for (int i = 0; i < FS_NUM; i++)
      write_reg(reg_idx_t'(int'(REG_FS0) + i), {1'($urandom_range(1)), fs[i]});
  endtask

  function automatic logic [FS_NUM-1:0][VOLT_W-1:0] random_full_scales(bit falling);
    logic [FS_NUM-1:0][VOLT_W-1:0] fs;
    longint                        v;
    v = $urandom_range(1000, 8388607);
    for (int i = 0; i < FS_NUM; i++) begin
      if (falling) begin
        fs[i] = v[VOLT_W-1:0];
        v = v * $urandom_range(30, 95) / 100;
      end else begin
        case ($urandom_range(5))
          0: fs[i] = '0;
          1: fs[i] = 23'h7fffff;
          default: fs[i] = VOLT_W'($urandom);
        endcase
      end
    end
    return fs;
  endfunction

  task automatic run_random(int count);
    logic [IN_D_W-1:0] samples;
    for (int n = 0; n < count; n++) begin
      for (int c = 0; c < MAX_CH; c++) samples[c*SAMPLE_W +: SAMPLE_W] = pick_sample(c);
      send_samples(samples);
    end
  endtask

  // eleven crossings of the default limit flag a channel; the limit itself does not count
  task automatic test_overvoltage_trip();
    repeat (11) send_samples({-24'sd6144000, 24'sd6000000, 24'sd6000001, MOST_NEG});
  endtask

  // with zero delay a low signal narrows by one step on every item until the highest gain index
  task automatic test_zero_delay_narrowing();
    program_registers('0, OV_LIM_RST, FS_RST);
    repeat (6) send_samples({24'sd100000, -24'sd1, 24'sd1, 24'sd0});
  endtask

  // large samples widen one step per item; exactly 19/20 of full scale does not
  task automatic test_widen_steps();
    send_samples({24'sd243200, 24'sd0, 24'sd0, 24'sd0});
    send_samples({24'sd0, 24'sd243201, -24'sd6144000, 24'h7fffff});
    repeat (2) send_samples({24'sd0, 24'sd243201, -24'sd6144000, 24'h7fffff});
  endtask

  task automatic test_short_delay();
    program_registers(24'd3, OV_LIM_RST, FS_RST);
    run_random(350);
  endtask

  task automatic test_max_settings();
    send_idle_pct = 51;
    program_registers(24'hffffff, '0, {FS_NUM{23'h7fffff}});
    run_random(300);
  endtask

  task automatic test_small_ranges();
    send_idle_pct  = 0;
    recv_stall_pct = 51;
    program_registers(24'd1, 23'h7fffff,
                      {23'd5000, 23'd20000, 23'd50000, 23'd100000, 23'd200000, 23'd400000});
    run_random(350);
  endtask

  task automatic test_random_falling_ranges();
    send_idle_pct  = 32;
    recv_stall_pct = 32;
    program_registers('0, VOLT_W'($urandom), random_full_scales(1'b1));
    run_random(350);
  endtask

  // short phases with random settings and idling
  task automatic test_random_settings();
    for (int k = 0; k < 7; k++) begin
      send_idle_pct  = (k % 4 == 1) ? 51 : (k % 4 == 3) ? 32 : 0;
      recv_stall_pct = (k % 4 == 2) ? 51 : (k % 4 == 3) ? 32 : 0;
      program_registers(DELAY_W'($urandom_range(0, 20)), VOLT_W'($urandom),
                        random_full_scales(k[0]));
      run_random(50);
    end
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_word = out_tdata;
      if (expected_words.size() == 0) begin
        mismatch_count++;
        $display("%0t: result with nothing expected, expected none actual %h", $time, out_tdata);
      end else begin
        want_word = expected_words.pop_front();
        for (int c = 0; c < MAX_CH; c++)
          report_field($sformatf("gain_ch%0d", c), want_word.gain[c], got_word.gain[c]);
        report_field("gain_changed", want_word.changed, got_word.changed);
        report_field("overvoltage_mask", want_word.ov_mask, got_word.ov_mask);
        report_field("zero fill", want_word.fill, got_word.fill);
      end
    end
  end

  // receiver stalls
  always @(negedge clk) begin
    out_tready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
  end

  // watchdog on cycles where nothing moves
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin
    delay_cfg    = DELAY_RST;
    ov_limit_cfg = OV_LIM_RST;
    for (int i = 0; i < FS_NUM; i++) fs_cfg[i] = FS_RST[i];
    for (int c = 0; c < MAX_CH; c++) begin
      gain_st[c]      = '0;
      countdown_st[c] = '0;
      ov_count_st[c]  = '0;
      quiet_left[c]   = 0;
    end
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_overvoltage_trip();
    test_zero_delay_narrowing();
    test_widen_steps();
    test_short_delay();
    test_max_settings();
    test_small_ranges();
    test_random_falling_ranges();
    test_random_settings();

    drain();
    repeat (8) @(negedge clk);
    if (mismatch_count == 0 && expected_words.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ auto_range_gain_with_overvoltage.f @@
rtl/arg_pkg.sv
rtl/arg_lane.sv
rtl/arg_merge.sv
rtl/auto_range_gain_with_overvoltage.sv
test/tb_auto_range_gain_with_overvoltage.sv
